FILE: src/stepper_jog_speed_ramp_unit_assert.svh
// assertion macros for the ramp unit modules, included by the queue
`ifndef STEPPER_JOG_SPEED_RAMP_UNIT_ASSERT_SVH
`define STEPPER_JOG_SPEED_RAMP_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SJSR_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sjsr: assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SJSR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sjsr: assertion failed");

`endif

FILE: src/sjsr_pkg.sv
`default_nettype none

package sjsr_pkg;

    localparam int SPEED_FRAC_BITS = 16;
    localparam int POSITION_BITS   = 24;

    localparam int MS_W       = 8;
    localparam int POS_W      = POSITION_BITS;
    localparam int SPD_W      = 24;
    localparam int RPM_W      = 14;
    localparam int RATE_W     = 24;
    localparam int HALF_W     = 20;
    localparam int RAMP_W     = 23;
    localparam int FRPM_W     = 12;
    localparam int SPR_W      = 16;
    localparam int THR_W      = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int PROD_W = MS_W + RAMP_W;
    localparam int SUM_W  = PROD_W + 2;

    localparam int DVD_W   = SPD_W + FRPM_W;
    localparam int DSR_W   = RATE_W;
    localparam int QUO_W   = RATE_W;
    localparam int DSH_W   = DSR_W + QUO_W;
    localparam int CNT_W   = $clog2(QUO_W + 1);
    localparam int RPM_Q_W = 13;

    // rounded-up reciprocals, exact over the product ranges they see
    localparam int RPM_Y_W        = DVD_W - SPEED_FRAC_BITS;
    localparam int RATE_Z_W       = RPM_Q_W + SPR_W;
    localparam int HUND_RECIP_SH  = 26;
    localparam int HUND_RECIP_W   = 20;
    localparam int SIXTY_RECIP_SH = 35;
    localparam int SIXTY_RECIP_W  = 30;
    localparam int REC1_W         = RPM_Y_W + HUND_RECIP_W;
    localparam int REC2_W         = RATE_Z_W + SIXTY_RECIP_W;

    localparam logic [HUND_RECIP_W-1:0] HUND_RECIP =
        HUND_RECIP_W'(((longint'(1) << HUND_RECIP_SH) + 99) / 100);
    localparam logic [SIXTY_RECIP_W-1:0] SIXTY_RECIP =
        SIXTY_RECIP_W'(((longint'(1) << SIXTY_RECIP_SH) + 59) / 60);

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic signed [SPD_W-1:0] SPD_HUND  = SPD_W'(100 << SPEED_FRAC_BITS);
    localparam logic signed [SPD_W-1:0] SPD_NHUND = -SPD_HUND;
    localparam logic signed [SPD_W-1:0] SPD_ONE   = SPD_W'(1 << SPEED_FRAC_BITS);
    localparam logic signed [SPD_W-1:0] SPD_NONE  = -SPD_ONE;
    localparam logic [SPD_W-1:0]        MAG_ONE   = SPD_W'(1 << SPEED_FRAC_BITS);

    localparam logic [DVD_W-1:0] US_PER_SEC = DVD_W'(1000000);

    localparam logic [CNT_W-1:0] N_HALF = CNT_W'(HALF_W);

    localparam logic [HALF_W-1:0] HALF_NEAR_STOP = HALF_W'(1000);
    localparam logic [HALF_W-1:0] HALF_SAT       = HALF_W'(1000000);

    localparam logic [RATE_W-1:0] RATE_LIM_POS = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic [RATE_W-1:0] RATE_LIM_NEG = {1'b1, {(RATE_W-1){1'b0}}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACCEL_RATE,
        CFG_DECEL_RATE,
        CFG_FULL_RPM,
        CFG_STEPS_PER_REV,
        CFG_UPPER_SLOW,
        CFG_LOWER_SLOW,
        CFG_MAX_TRAVEL
    } cfg_idx_t;

    typedef struct packed {
        logic [RAMP_W-1:0]       accel_rate;
        logic [RAMP_W-1:0]       decel_rate;
        logic [FRPM_W-1:0]       full_rpm;
        logic [SPR_W-1:0]        steps_per_rev;
        logic signed [THR_W-1:0] upper_slow_steps;
        logic signed [THR_W-1:0] lower_slow_steps;
        logic signed [THR_W-1:0] max_travel_steps;
    } cfg_t;

    typedef struct packed {
        logic signed [SPD_W-1:0] speed;
        logic                    datum;
        logic                    homed;
        logic                    clr;
    } ramp_item_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
        logic [CNT_W-1:0] nbits;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quotient;
    } div_rsp_t;

    function automatic logic signed [SPD_W-1:0] sat_spd(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-SPD_W:0] top;
        top = v[SUM_W-1:SPD_W-1];
        if (top == '0 || top == '1)
        begin
            return v[SPD_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            return {1'b1, {(SPD_W-1){1'b0}}};
        end
        else
        begin
            return {1'b0, {(SPD_W-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/sjsr_if.sv
`default_nettype none

interface sjsr_in_if import sjsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [MS_W-1:0]         elapsed_ms;
    logic                    jog_forward;
    logic                    jog_reverse;
    logic                    datum_switch;
    logic signed [POS_W-1:0] position_steps;

    modport source (
        output valid, elapsed_ms, jog_forward, jog_reverse, datum_switch, position_steps,
        input  ready
    );
    modport sink (
        input  valid, elapsed_ms, jog_forward, jog_reverse, datum_switch, position_steps,
        output ready
    );
endinterface

interface sjsr_out_if import sjsr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [SPD_W-1:0]  speed_pct;
    logic signed [RPM_W-1:0]  motor_rpm;
    logic signed [RATE_W-1:0] step_rate;
    logic [HALF_W-1:0]        half_period_us;
    logic                     run_cw;
    logic                     run_ccw;
    logic                     homed;
    logic                     clear_position;

    modport source (
        output valid, speed_pct, motor_rpm, step_rate, half_period_us,
               run_cw, run_ccw, homed, clear_position,
        input  ready
    );
    modport sink (
        input  valid, speed_pct, motor_rpm, step_rate, half_period_us,
               run_cw, run_ccw, homed, clear_position,
        output ready
    );
endinterface

`default_nettype wire

FILE: src/sjsr_front.sv
`default_nettype none

module sjsr_front import sjsr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    sjsr_in_if.sink    tick,
    output logic       push,
    output ramp_item_t push_data,
    input  logic       full
);

    typedef enum logic [2:0] {
        F_IDLE,
        F_CALC,
        F_RAMP_F,
        F_RAMP_R,
        F_DECAY_P,
        F_DECAY_N,
        F_PUSH
    } fstate_t;

    fstate_t                 state_reg;
    logic [MS_W-1:0]         ms_reg;
    logic                    fwd_reg;
    logic                    rev_reg;
    logic                    ds_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic signed [SPD_W-1:0] speed_reg;
    logic                    homed_reg;
    logic signed [SPD_W-1:0] work_reg;
    logic [PROD_W-1:0]       add_reg;
    logic [PROD_W-1:0]       sub_reg;
    logic                    clr_reg;
    logic                    over_reg;
    logic                    low_reg;
    logic                    slow_reg;
    logic                    dec_reg;

    logic                    clr;
    logic                    homed_new;
    logic signed [POS_W-1:0] pos_eff;
    logic                    over;
    logic                    low;
    logic                    slow;
    logic                    spd_pos;
    logic                    work_pos;
    logic                    dec;
    logic signed [SUM_W-1:0] sum_up;
    logic signed [SUM_W-1:0] sum_dn;
    logic signed [SUM_W-1:0] dec_sub;
    logic signed [SUM_W-1:0] dec_add;
    logic signed [SPD_W-1:0] work_next;

    always_comb
    begin
        clr       = fwd_reg & ~ds_reg;
        homed_new = homed_reg | clr;
        pos_eff   = clr ? POS_W'(0) : pos_reg;
        over      = pos_eff > cfg.max_travel_steps;
        low       = !homed_new || (fwd_reg && pos_eff < cfg.lower_slow_steps) ||
                    (rev_reg && pos_eff > cfg.upper_slow_steps);
        spd_pos   = !speed_reg[SPD_W-1] && (speed_reg != SPD_W'(0));
        slow      = (spd_pos && !fwd_reg) || (speed_reg[SPD_W-1] && !rev_reg);
        work_pos  = !work_reg[SPD_W-1] && (work_reg != SPD_W'(0));
        dec       = (!fwd_reg && !rev_reg) || slow_reg ||
                    (low_reg && (work_reg > SPD_HUND || work_reg < SPD_NHUND));
        sum_up    = SUM_W'(work_reg) + SUM_W'(add_reg);
        sum_dn    = SUM_W'(work_reg) - SUM_W'(add_reg);
        dec_sub   = SUM_W'(work_reg) - SUM_W'(sub_reg);
        dec_add   = SUM_W'(work_reg) + SUM_W'(sub_reg);

        work_next = work_reg;
        if (dec_reg && work_reg[SPD_W-1])
        begin
            work_next = (work_reg > SPD_NONE) ? SPD_W'(0) : sat_spd(dec_add);
        end
        if (over_reg && rev_reg && homed_reg)
        begin
            work_next = SPD_W'(0);
        end
    end

    assign tick.ready = (state_reg == F_IDLE);
    assign push       = (state_reg == F_PUSH) && !full;

    always_comb
    begin
        push_data.speed = work_reg;
        push_data.datum = ds_reg;
        push_data.homed = homed_reg;
        push_data.clr   = clr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            speed_reg <= '0;
            homed_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                F_IDLE:
                begin
                    if (tick.valid)
                    begin
                        ms_reg    <= tick.elapsed_ms;
                        fwd_reg   <= tick.jog_forward;
                        rev_reg   <= tick.jog_reverse;
                        ds_reg    <= tick.datum_switch;
                        pos_reg   <= tick.position_steps;
                        state_reg <= F_CALC;
                    end
                end
                F_CALC:
                begin
                    add_reg   <= PROD_W'(ms_reg) * PROD_W'(cfg.accel_rate);
                    sub_reg   <= PROD_W'(ms_reg) * PROD_W'(cfg.decel_rate);
                    clr_reg   <= clr;
                    homed_reg <= homed_new;
                    over_reg  <= over;
                    low_reg   <= low;
                    slow_reg  <= slow;
                    work_reg  <= speed_reg;
                    state_reg <= F_RAMP_F;
                end
                F_RAMP_F:
                begin
                    if (fwd_reg && work_reg < SPD_HUND)
                    begin
                        work_reg <= sat_spd(sum_up);
                    end
                    state_reg <= F_RAMP_R;
                end
                F_RAMP_R:
                begin
                    if (rev_reg && work_reg > SPD_NHUND && (!low_reg || work_reg < SPD_HUND))
                    begin
                        work_reg <= sat_spd(sum_dn);
                    end
                    state_reg <= F_DECAY_P;
                end
                F_DECAY_P:
                begin
                    dec_reg <= dec;
                    if (dec && work_pos)
                    begin
                        work_reg <= (work_reg < SPD_ONE) ? SPD_W'(0) : sat_spd(dec_sub);
                    end
                    state_reg <= F_DECAY_N;
                end
                F_DECAY_N:
                begin
                    work_reg  <= work_next;
                    speed_reg <= work_next;
                    state_reg <= F_PUSH;
                end
                F_PUSH:
                begin
                    if (!full)
                    begin
                        state_reg <= F_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/sjsr_queue.sv
`default_nettype none
`include "stepper_jog_speed_ramp_unit_assert.svh"

module sjsr_queue import sjsr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  ramp_item_t push_data,
    output logic       full,
    input  logic       pop,
    output ramp_item_t pop_data,
    output logic       empty
);

    ramp_item_t         mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full     = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (count_reg == Q_CNT_W'(0));
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `SJSR_ASSERT_IMPLIES(a_no_push_when_full, push, !full)
    `SJSR_ASSERT_IMPLIES(a_no_pop_when_empty, pop, !empty)
    `SJSR_ASSERT_NEXT(a_push_leaves_entry, push && !pop, !empty)
    `SJSR_ASSERT_NEXT(a_pop_drops_count, pop && !push, count_reg == $past(count_reg) - 1'b1)

endmodule

`default_nettype wire

FILE: src/sjsr_div.sv
`default_nettype none

module sjsr_div import sjsr_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DVD_W-1:0] rem_reg;
    logic [DSH_W-1:0] dsh_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic             ge;
    logic [DVD_W-1:0] rem_diff;

    assign ge       = DSH_W'(rem_reg) >= dsh_reg;
    assign rem_diff = rem_reg - dsh_reg[DVD_W-1:0];

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                rem_reg  <= req.dividend;
                dsh_reg  <= DSH_W'(req.divisor) << (req.nbits - 1'b1);
                quo_reg  <= '0;
                cnt_reg  <= req.nbits;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (ge)
                begin
                    rem_reg <= rem_diff;
                end
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: src/sjsr_back.sv
`default_nettype none

module sjsr_back import sjsr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    output logic       pop,
    input  ramp_item_t pop_data,
    input  logic       empty,
    sjsr_out_if.source result
);

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL1,
        B_REC1,
        B_MUL2,
        B_REC2,
        B_SAT,
        B_DIV3,
        B_DONE
    } bstate_t;

    bstate_t                  state_reg;
    ramp_item_t               item_reg;
    div_req_t                 req_reg;
    div_rsp_t                 rsp;
    logic [DVD_W-1:0]         prod_reg;
    logic [RPM_Q_W-1:0]       rpm_mag_reg;
    logic [QUO_W-1:0]         rate_mag_reg;
    logic signed [RPM_W-1:0]  rpm_res_reg;
    logic signed [RATE_W-1:0] rate_res_reg;
    logic [HALF_W-1:0]        half_reg;

    logic                     out_valid_reg;
    logic signed [SPD_W-1:0]  o_speed_reg;
    logic signed [RPM_W-1:0]  o_rpm_reg;
    logic signed [RATE_W-1:0] o_rate_reg;
    logic [HALF_W-1:0]        o_half_reg;
    logic                     o_cw_reg;
    logic                     o_ccw_reg;
    logic                     o_homed_reg;
    logic                     o_clr_reg;

    logic                     neg;
    logic [SPD_W-1:0]         smag;
    logic [DVD_W-1:0]         prod1;
    logic [DVD_W-1:0]         prod2;
    logic [REC1_W-1:0]        rec1;
    logic [REC2_W-1:0]        rec2;
    logic [RATE_W-1:0]        rate_lim;
    logic [RATE_W-1:0]        rate_abs;
    logic signed [RATE_W-1:0] rate_signed;
    logic signed [RPM_W-1:0]  rpm_signed;
    logic                     big;
    logic                     spd_pos;

    sjsr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_reg),
        .rsp   (rsp)
    );

    always_comb
    begin
        neg         = item_reg.speed[SPD_W-1];
        smag        = neg ? (~item_reg.speed + 1'b1) : item_reg.speed;
        prod1       = DVD_W'(smag) * DVD_W'(cfg.full_rpm);
        prod2       = DVD_W'(rpm_mag_reg) * DVD_W'(cfg.steps_per_rev);
        // divide by 100 after dropping the fraction bits, then by 60
        rec1        = REC1_W'(prod_reg[DVD_W-1:SPEED_FRAC_BITS]) * REC1_W'(HUND_RECIP);
        rec2        = REC2_W'(prod_reg[RATE_Z_W-1:0]) * REC2_W'(SIXTY_RECIP);
        rate_lim    = neg ? RATE_LIM_NEG : RATE_LIM_POS;
        rate_abs    = (rate_mag_reg > rate_lim) ? rate_lim : rate_mag_reg;
        rate_signed = neg ? (~rate_abs + 1'b1) : rate_abs;
        rpm_signed  = neg ? (~RPM_W'(rpm_mag_reg) + 1'b1) : RPM_W'(rpm_mag_reg);
        big         = smag >= MAG_ONE;
        spd_pos     = !neg && (item_reg.speed != SPD_W'(0));
    end

    assign pop = (state_reg == B_IDLE) && !empty;

    assign result.valid          = out_valid_reg;
    assign result.speed_pct      = o_speed_reg;
    assign result.motor_rpm      = o_rpm_reg;
    assign result.step_rate      = o_rate_reg;
    assign result.half_period_us = o_half_reg;
    assign result.run_cw         = o_cw_reg;
    assign result.run_ccw        = o_ccw_reg;
    assign result.homed          = o_homed_reg;
    assign result.clear_position = o_clr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            req_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_reg.start <= 1'b0;
            if (out_valid_reg && result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!empty)
                    begin
                        item_reg  <= pop_data;
                        state_reg <= B_MUL1;
                    end
                end
                B_MUL1:
                begin
                    prod_reg  <= prod1;
                    state_reg <= B_REC1;
                end
                B_REC1:
                begin
                    rpm_mag_reg <= rec1[HUND_RECIP_SH +: RPM_Q_W];
                    state_reg   <= B_MUL2;
                end
                B_MUL2:
                begin
                    prod_reg  <= prod2;
                    state_reg <= B_REC2;
                end
                B_REC2:
                begin
                    rate_mag_reg <= rec2[SIXTY_RECIP_SH +: QUO_W];
                    state_reg    <= B_SAT;
                end
                B_SAT:
                begin
                    rpm_res_reg  <= rpm_signed;
                    rate_res_reg <= rate_signed;
                    if (!big)
                    begin
                        half_reg  <= HALF_NEAR_STOP;
                        state_reg <= B_DONE;
                    end
                    else if (rate_abs == RATE_W'(0))
                    begin
                        half_reg  <= HALF_SAT;
                        state_reg <= B_DONE;
                    end
                    else
                    begin
                        req_reg.start    <= 1'b1;
                        req_reg.dividend <= US_PER_SEC;
                        req_reg.divisor  <= DSR_W'(rate_abs);
                        req_reg.nbits    <= N_HALF;
                        state_reg        <= B_DIV3;
                    end
                end
                B_DIV3:
                begin
                    if (rsp.done)
                    begin
                        half_reg  <= rsp.quotient[HALF_W-1:0];
                        state_reg <= B_DONE;
                    end
                end
                B_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        o_speed_reg   <= item_reg.speed;
                        o_rpm_reg     <= rpm_res_reg;
                        o_rate_reg    <= rate_res_reg;
                        o_half_reg    <= half_reg;
                        o_cw_reg      <= item_reg.datum && spd_pos;
                        o_ccw_reg     <= neg;
                        o_homed_reg   <= item_reg.homed;
                        o_clr_reg     <= item_reg.clr;
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: src/stepper_jog_speed_ramp_unit.sv
// front end: takes a tick only when idle, ramps the speed and pushes one item into the two-entry
// queue, waiting while it is full; back end: pops one item at a time, finds rpm and step rate and,
// at one percent or more with a nonzero rate, the half period with the 20-bit bit-serial divider;
// below one percent or at zero rate the divider is skipped, and the result waits for result ready
// reset: asynchronous active-low rst_n clears speed, homed flag, queue, state machines,
// output valid, and loads the configuration registers with their defaults
`default_nettype none

module stepper_jog_speed_ramp_unit import sjsr_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    sjsr_in_if.sink               tick,
    sjsr_out_if.source            result
);

    cfg_t       cfg_reg;
    logic       push;
    ramp_item_t push_data;
    logic       full;
    logic       pop;
    ramp_item_t pop_data;
    logic       empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.accel_rate       <= RAMP_W'(8192);
            cfg_reg.decel_rate       <= RAMP_W'(8192);
            cfg_reg.full_rpm         <= FRPM_W'(400);
            cfg_reg.steps_per_rev    <= SPR_W'(3200);
            cfg_reg.upper_slow_steps <= THR_W'(127909);
            cfg_reg.lower_slow_steps <= THR_W'(15989);
            cfg_reg.max_travel_steps <= THR_W'(142941);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ACCEL_RATE:    cfg_reg.accel_rate       <= cfg_data[RAMP_W-1:0];
                CFG_DECEL_RATE:    cfg_reg.decel_rate       <= cfg_data[RAMP_W-1:0];
                CFG_FULL_RPM:      cfg_reg.full_rpm         <= cfg_data[FRPM_W-1:0];
                CFG_STEPS_PER_REV: cfg_reg.steps_per_rev    <= cfg_data[SPR_W-1:0];
                CFG_UPPER_SLOW:    cfg_reg.upper_slow_steps <= cfg_data[THR_W-1:0];
                CFG_LOWER_SLOW:    cfg_reg.lower_slow_steps <= cfg_data[THR_W-1:0];
                CFG_MAX_TRAVEL:    cfg_reg.max_travel_steps <= cfg_data[THR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    sjsr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .tick      (tick),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    sjsr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    sjsr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty),
        .result   (result)
    );

endmodule

`default_nettype wire
